// ===== design/vmdaw_pkg.sv =====
package vmdaw_pkg;

  localparam int NREG = 8;
  localparam int CFG_IDX_W = 4;
  localparam int ATAN_LEN = 40;
  localparam int CW = 34;
  localparam int MW = 40;
  localparam int PW = 36;
  localparam int SQRT_STEPS = 32;

  localparam logic [3:0] REG_0_00  = 4'd0;
  localparam logic [3:0] REG_0_10  = 4'd1;
  localparam logic [3:0] REG_0_1M1 = 4'd2;
  localparam logic [3:0] REG_1_11  = 4'd3;
  localparam logic [3:0] REG_1_00  = 4'd4;
  localparam logic [3:0] REG_1_10  = 4'd5;
  localparam logic [3:0] REG_1_1M1 = 4'd6;
  localparam logic [3:0] REG_2_10  = 4'd7;

  localparam logic signed [MW-1:0] ONE_Q30   = 40'sd1073741824;
  localparam logic signed [MW-1:0] SQRT2_Q30 = 40'sd1518500250;
  localparam logic [27:0] SCALE_Q30 = 28'd256336978;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
  localparam logic [34:0] WSUM_LIM = 35'h4_0000_0000;
  localparam int DEF_SDM_2_1M1 = 0;
  localparam int DEF_CORDIC_STEPS = 30;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [MW-1:0] mop_t;
  typedef logic signed [PW-1:0] prod_t;

  function automatic cval_t atan_bam(input int i);
    cval_t r;
    case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10679838;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // operands clamp to [-2, 2] in Q2.30, product floored by 2^30
  function automatic prod_t mul(input mop_t a, input mop_t b);
    logic signed [32:0] ca;
    logic signed [32:0] cb;
    logic signed [65:0] p;
    logic signed [65:0] q;
    if (a > 40'sh0080000000) ca = 33'sh080000000;
    else if (a < -40'sh0080000000) ca = -33'sh080000000;
    else ca = a[32:0];
    if (b > 40'sh0080000000) cb = 33'sh080000000;
    else if (b < -40'sh0080000000) cb = -33'sh080000000;
    else cb = b[32:0];
    p = 66'(ca) * 66'(cb);
    q = p >>> 30;
    return q[PW-1:0];
  endfunction

endpackage

// ===== design/vector_meson_decay_angular_weight.sv =====
// Angular weight of a vector meson decay under a linearly polarised photon.
// Fully pipelined: one event is accepted per cycle unless a result stalls.
// Stages: two angle conversion stages, one CORDIC cell per step for phi, 2phi
// and 2Phi, five arithmetic stages, one square-root cell per result bit and
// the output register.  The whole pipeline holds while a result waits on
// out_ready.  The eight density elements are to be written over the cfg
// channel only while idle; the block does not enforce this.  The ninth is
// the SDM_2_1M1 parameter.
module vector_meson_decay_angular_weight import vmdaw_pkg::*; #(
  parameter int SDM_2_1M1 = DEF_SDM_2_1M1,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   cos_theta,
  input  logic [30:0]          sin_sq_theta,
  input  logic signed [31:0]   sin_two_theta,
  input  logic signed [30:0]   azimuth,
  input  logic signed [30:0]   pol_plane_angle,
  input  logic [30:0]          pol_degree,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [30:0]          amplitude,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int N = CORDIC_STEPS;
  localparam int NST = N + 40;
  localparam mop_t P21 = 40'(SDM_2_1M1);

  logic en;
  logic [NST-1:0] vld;
  logic signed [31:0] sdm [NREG];

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) sdm[i] <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NREG)) begin
      sdm[cfg_index[2:0]] <= cfg_data;
    end
  end

  // stage 1: radian magnitude times turn scale
  logic [30:0] mag_p, mag_b;
  logic [60:0] s1_pp, s1_pb;
  logic s1_np, s1_nb;
  logic signed [31:0] s1_ct, s1_s2t;
  logic [30:0] s1_ssq, s1_pg;

  assign mag_p = azimuth[30] ? 31'(-azimuth) : 31'(azimuth);
  assign mag_b = pol_plane_angle[30] ? 31'(-pol_plane_angle) : 31'(pol_plane_angle);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pp <= 61'(mag_p) * 61'(RAD_TO_BAM);
      s1_pb <= 61'(mag_b) * 61'(RAD_TO_BAM);
      s1_np <= azimuth[30];
      s1_nb <= pol_plane_angle[30];
      s1_ct <= cos_theta;
      s1_s2t <= sin_two_theta;
      s1_ssq <= sin_sq_theta;
      s1_pg <= pol_degree;
    end
  end

  // stage 2: binary angles, doubling, fold into the right half plane
  logic [60:0] rp, rb;
  logic [31:0] qp, qb, bp, bb;
  logic [31:0] ang [3];
  logic [31:0] fang [3];
  logic fl [3];

  assign rp = s1_pp + 61'd134217728;
  assign rb = s1_pb + 61'd134217728;
  assign qp = rp[59:28];
  assign qb = rb[59:28];
  assign bp = s1_np ? 32'(-qp) : qp;
  assign bb = s1_nb ? 32'(-qb) : qb;
  assign ang[0] = bp;
  assign ang[1] = {bp[30:0], 1'b0};
  assign ang[2] = {bb[30:0], 1'b0};

  cval_t cx [3][N+1];
  cval_t cy [3][N+1];
  cval_t cz [3][N+1];
  logic s2_fl [3];
  logic signed [31:0] s2_ct, s2_s2t;
  logic [30:0] s2_ssq, s2_pg;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if ($signed(ang[l]) > 32'sh40000000 || $signed(ang[l]) < -32'sh40000000) begin
        fang[l] = ang[l] ^ 32'h80000000;
        fl[l] = 1'b1;
      end else begin
        fang[l] = ang[l];
        fl[l] = 1'b0;
      end
    end
  end

  generate
    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          cx[l][0] <= GAIN_Q30;
          cy[l][0] <= '0;
          cz[l][0] <= CW'($signed(fang[l]));
          s2_fl[l] <= fl[l];
        end
      end
      for (genvar k = 0; k < N; k++) begin : g_step
        vmdaw_cordic_cell #(.STEP(k)) u_cell (
          .clk (clk),
          .en  (en),
          .x_in(cx[l][k]),
          .y_in(cy[l][k]),
          .z_in(cz[l][k]),
          .x   (cx[l][k+1]),
          .y   (cy[l][k+1]),
          .z   (cz[l][k+1])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ct <= s1_ct;
      s2_s2t <= s1_s2t;
      s2_ssq <= s1_ssq;
      s2_pg <= s1_pg;
    end
  end

  // side data alongside the CORDIC cells
  logic signed [31:0] d_ct [N];
  logic signed [31:0] d_s2t [N];
  logic [30:0] d_ssq [N];
  logic [30:0] d_pg [N];
  logic [2:0] d_fl [N];

  always_ff @(posedge clk) begin
    if (en) begin
      d_ct[0] <= s2_ct;
      d_s2t[0] <= s2_s2t;
      d_ssq[0] <= s2_ssq;
      d_pg[0] <= s2_pg;
      d_fl[0] <= {s2_fl[2], s2_fl[1], s2_fl[0]};
      for (int k = 1; k < N; k++) begin
        d_ct[k] <= d_ct[k-1];
        d_s2t[k] <= d_s2t[k-1];
        d_ssq[k] <= d_ssq[k-1];
        d_pg[k] <= d_pg[k-1];
        d_fl[k] <= d_fl[k-1];
      end
    end
  end

  // stage A: sin/cos with fold sign, first products
  cval_t cp, sp, c2p, s2p, c2bb, s2bb;
  mop_t ct_m, s2t_m, ssq_m, pg_m;

  assign cp = d_fl[N-1][0] ? -cx[0][N] : cx[0][N];
  assign sp = d_fl[N-1][0] ? -cy[0][N] : cy[0][N];
  assign c2p = d_fl[N-1][1] ? -cx[1][N] : cx[1][N];
  assign s2p = d_fl[N-1][1] ? -cy[1][N] : cy[1][N];
  assign c2bb = d_fl[N-1][2] ? -cx[2][N] : cx[2][N];
  assign s2bb = d_fl[N-1][2] ? -cy[2][N] : cy[2][N];
  assign ct_m = MW'(d_ct[N-1]);
  assign s2t_m = MW'(d_s2t[N-1]);
  assign ssq_m = {9'd0, d_ssq[N-1]};
  assign pg_m = {9'd0, d_pg[N-1]};

  prod_t a_c2, a_tcp, a_tc2p, a_g, a_h, a_tsp, a_ts2p, a_k1, a_k5, a_k7;
  logic [30:0] a_ssq;

  always_ff @(posedge clk) begin
    if (en) begin
      a_c2 <= mul(ct_m, ct_m);
      a_tcp <= mul(s2t_m, MW'(cp));
      a_tc2p <= mul(ssq_m, MW'(c2p));
      a_g <= mul(pg_m, MW'(c2bb));
      a_h <= mul(pg_m, MW'(s2bb));
      a_tsp <= mul(s2t_m, MW'(sp));
      a_ts2p <= mul(ssq_m, MW'(s2p));
      a_k1 <= mul(SQRT2_Q30, MW'(sdm[REG_0_10[2:0]]));
      a_k5 <= mul(SQRT2_Q30, MW'(sdm[REG_1_10[2:0]]));
      a_k7 <= mul(SQRT2_Q30, MW'(sdm[REG_2_10[2:0]]));
      a_ssq <= d_ssq[N-1];
    end
  end

  // stage B: element products
  prod_t b_q0, b_m1, b_m2, b_p3, b_p4, b_p5, b_p6, b_p7, b_p8, b_g, b_h, b_c2;
  mop_t r0_m;

  assign r0_m = MW'(sdm[REG_0_00[2:0]]);

  always_ff @(posedge clk) begin
    if (en) begin
      b_q0 <= mul(r0_m, MW'(a_c2));
      b_m1 <= mul(MW'(a_k1), MW'(a_tcp));
      b_m2 <= mul(MW'(sdm[REG_0_1M1[2:0]]), MW'(a_tc2p));
      b_p3 <= mul(MW'(sdm[REG_1_11[2:0]]), {9'd0, a_ssq});
      b_p4 <= mul(MW'(sdm[REG_1_00[2:0]]), MW'(a_c2));
      b_p5 <= mul(MW'(a_k5), MW'(a_tcp));
      b_p6 <= mul(MW'(sdm[REG_1_1M1[2:0]]), MW'(a_tc2p));
      b_p7 <= mul(MW'(a_k7), MW'(a_tsp));
      b_p8 <= mul(P21, MW'(a_ts2p));
      b_g <= a_g;
      b_h <= a_h;
      b_c2 <= a_c2;
    end
  end

  // stage C: polarised products and unpolarised partial sum
  mop_t c_s;
  prod_t c_e3, c_e4, c_e5, c_e6, c_e7, c_e8;
  mop_t t_a, t_b;

  assign t_a = (ONE_Q30 - r0_m) >>> 1;
  assign t_b = (3 * MW'(b_q0) - MW'(b_c2)) >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      c_s <= t_a + t_b - MW'(b_m1) - MW'(b_m2);
      c_e3 <= mul(MW'(b_g), MW'(b_p3));
      c_e4 <= mul(MW'(b_g), MW'(b_p4));
      c_e5 <= mul(MW'(b_g), MW'(b_p5));
      c_e6 <= mul(MW'(b_g), MW'(b_p6));
      c_e7 <= mul(MW'(b_h), MW'(b_p7));
      c_e8 <= mul(MW'(b_h), MW'(b_p8));
    end
  end

  // stage D: total, magnitude, limit
  mop_t w, wa;
  logic [34:0] d_u;

  assign w = c_s - MW'(c_e3) - MW'(c_e4) + MW'(c_e5) + MW'(c_e6)
             - MW'(c_e7) - MW'(c_e8);
  assign wa = w[MW-1] ? -w : w;

  always_ff @(posedge clk) begin
    if (en) begin
      d_u <= (wa > MW'(WSUM_LIM)) ? WSUM_LIM : wa[34:0];
    end
  end

  // stage E: scale by 3/(4 pi)
  logic [62:0] e_prod;
  logic [63:0] sv [SQRT_STEPS+1];
  logic [63:0] sr [SQRT_STEPS+1];

  assign e_prod = 63'(d_u) * 63'(SCALE_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0] <= {1'b0, e_prod[62:30], 30'd0};
      sr[0] <= '0;
    end
  end

  generate
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      vmdaw_sqrt_cell #(.STEP(k)) u_cell (
        .clk (clk),
        .en  (en),
        .v_in(sv[k]),
        .r_in(sr[k]),
        .v   (sv[k+1]),
        .r   (sr[k+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      amplitude <= (sr[SQRT_STEPS] > 64'h7FFFFFFF) ? 31'h7FFFFFFF
                   : sr[SQRT_STEPS][30:0];
    end
  end

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_cfg_ignore: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index >= CFG_IDX_W'(NREG) |=>
      $stable(sdm[0]) && $stable(sdm[3]) && $stable(sdm[7]))
    else $error("write beyond register list changed an element");

endmodule

// ===== design/vmdaw_cordic_cell.sv =====
module vmdaw_cordic_cell import vmdaw_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cval_t x_in,
  input  cval_t y_in,
  input  cval_t z_in,
  output cval_t x,
  output cval_t y,
  output cval_t z
);

  localparam cval_t ATAN = atan_bam(STEP);

  cval_t dx, dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end
    end
  end

endmodule

// ===== design/vmdaw_sqrt_cell.sv =====
module vmdaw_sqrt_cell import vmdaw_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_in,
  input  logic [63:0] r_in,
  output logic [63:0] v,
  output logic [63:0] r
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v <= v_in - trial;
        r <= (r_in >> 1) + BIT;
      end else begin
        v <= v_in;
        r <= r_in >> 1;
      end
    end
  end

endmodule

// ===== test/vector_meson_decay_angular_weight_tb.sv =====
module vector_meson_decay_angular_weight_tb;
  import vmdaw_pkg::*;

  localparam int LATENCY = DEF_CORDIC_STEPS + 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint OP_LIM = 64'sd1 << 31;

  typedef struct {
    logic signed [31:0] ct;
    logic [30:0]        ssq;
    logic signed [31:0] s2t;
    logic signed [30:0] az;
    logic signed [30:0] pp;
    logic [30:0]        pg;
  } decay_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] cos_theta = '0;
  logic [30:0] sin_sq_theta = '0;
  logic signed [31:0] sin_two_theta = '0;
  logic signed [30:0] azimuth = '0;
  logic signed [30:0] pol_plane_angle = '0;
  logic [30:0] pol_degree = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [30:0] amplitude;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  longint sdm[NREG];
  logic [30:0] amp_expected[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  vector_meson_decay_angular_weight i_dut (.*);

  always #6 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint qmul(longint a, longint b);
    if (a > OP_LIM) a = OP_LIM;
    if (a < -OP_LIM) a = -OP_LIM;
    if (b > OP_LIM) b = OP_LIM;
    if (b < -OP_LIM) b = -OP_LIM;
    return (a * b) >>> 30;
  endfunction

  function automatic logic [31:0] rad_to_turns(longint rad);
    longint unsigned mag;
    logic [31:0] q;
    mag = (rad < 0) ? longint'(-rad) : longint'(rad);
    q = 32'((mag * 64'd683565276 + (64'd1 << 27)) >> 28);
    return (rad < 0) ? -q : q;
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
    longint atan_tab[31] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                             21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                             333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                             1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
    longint z, x, y, dx, dy, step_ang;
    bit flip;
    z = longint'(signed'(ang));
    flip = 0;
    if (z > Q30 || z < -Q30) begin
      ang ^= 32'h8000_0000;
      z = longint'(signed'(ang));
      flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
      step_ang = (i < 31) ? atan_tab[i] : 0;
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= step_ang;
      end else begin
        x += dx; y -= dy; z += step_ang;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [30:0] decay_amplitude(decay_t d);
    longint ct, ssq, s2t, pg, cp, sp, c2p, s2p, c2pp, s2pp, c2, g, h, w, t_cp, t_c2p;
    logic [31:0] a_phi, a_pp;
    longint unsigned v, root;
    ct = d.ct; ssq = d.ssq; s2t = d.s2t; pg = d.pg;
    a_phi = rad_to_turns(longint'(d.az));
    a_pp = rad_to_turns(longint'(d.pp));
    rotate(a_phi, cp, sp);
    rotate(a_phi << 1, c2p, s2p);
    rotate(a_pp << 1, c2pp, s2pp);
    c2 = qmul(ct, ct);
    t_cp = qmul(s2t, cp);
    t_c2p = qmul(ssq, c2p);
    w = (Q30 - sdm[REG_0_00]) >>> 1;
    w += (3 * qmul(sdm[REG_0_00], c2) - c2) >>> 1;
    w -= qmul(qmul(1518500250, sdm[REG_0_10]), t_cp);
    w -= qmul(sdm[REG_0_1M1], t_c2p);
    g = qmul(pg, c2pp);
    w -= qmul(g, qmul(sdm[REG_1_11], ssq));
    w -= qmul(g, qmul(sdm[REG_1_00], c2));
    w += qmul(g, qmul(qmul(1518500250, sdm[REG_1_10]), t_cp));
    w += qmul(g, qmul(sdm[REG_1_1M1], t_c2p));
    h = qmul(pg, s2pp);
    w -= qmul(h, qmul(qmul(1518500250, sdm[REG_2_10]), qmul(s2t, sp)));
    w -= qmul(h, qmul(longint'(DEF_SDM_2_1M1), qmul(ssq, s2p)));
    if (w < 0) w = -w;
    if (w > (64'sd1 << 34)) w = 64'sd1 << 34;
    v = (longint'(w) * 64'd256336978) >> 30;
    root = int_sqrt(v << 30);
    if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
    return root[30:0];
  endfunction

  // ---------------- receiver, checker, watchdog ----------------
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [30:0] exp_amp;
    if (!rst && out_valid && out_ready) begin
      if (amp_expected.size() == 0) begin
        $error("unexpected transaction: amplitude=%0d", amplitude);
        errors++;
      end else begin
        exp_amp = amp_expected.pop_front();
        if (amplitude !== exp_amp) begin
          $error("amplitude mismatch: expected %0d actual %0d", exp_amp, amplitude);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- shared tasks ----------------
  // called at a rising edge; leaves in_valid high after the accepting edge
  task automatic send_decay(decay_t d);
    if (in_valid && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    cos_theta <= d.ct;
    sin_sq_theta <= d.ssq;
    sin_two_theta <= d.s2t;
    azimuth <= d.az;
    pol_plane_angle <= d.pp;
    pol_degree <= d.pg;
    do @(posedge clk); while (!in_ready);
    amp_expected.push_back(decay_amplitude(d));
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (amp_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_sdm(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NREG) sdm[idx] = longint'(signed'(val));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_element();
    case ($urandom_range(5, 0))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return $urandom();
      default: return 32'($urandom_range(32'h8000_0000, 0)) - 32'h4000_0000;
    endcase
  endfunction

  function automatic decay_t rand_decay();
    decay_t d;
    bit raw;
    raw = ($urandom_range(99, 0) < 15);
    d.ct = raw ? $urandom() : 32'($urandom_range(32'h8000_0000, 0)) - 32'h4000_0000;
    d.ssq = raw ? 31'($urandom()) : 31'($urandom_range(32'h4000_0000, 0));
    d.s2t = raw ? $urandom() : 32'($urandom_range(32'h8000_0000, 0)) - 32'h4000_0000;
    d.az = raw ? 31'($urandom()) : 31'($urandom_range(1686629714, 0) - 843314857);
    d.pp = raw ? 31'($urandom()) : 31'($urandom_range(1686629714, 0) - 843314857);
    d.pg = raw ? 31'($urandom()) : 31'($urandom_range(32'h4000_0000, 0));
    return d;
  endfunction

  task automatic random_config();
    for (int i = 0; i < NREG; i++) write_sdm(CFG_IDX_W'(i), rand_element());
  endtask

  // ---------------- tests ----------------
  task automatic test_directed_extremes();
    decay_t list[$];
    decay_t d;
    d = '{32'sh4000_0000, 31'h4000_0000, 32'sh0, 31'sd0, 31'sd0, 31'h4000_0000};
    list.push_back(d);
    d = '{-32'sh4000_0000, 31'h0, -32'sh4000_0000, 31'sd843314857, -31'sd843314857,
          31'h4000_0000};
    list.push_back(d);
    d = '{32'sh0, 31'h4000_0000, 32'sh4000_0000, -31'sd843314857, 31'sd843314857, 31'h0};
    list.push_back(d);
    d = '{32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 31'sh3FFF_FFFF, 31'sh3FFF_FFFF,
          31'h7FFF_FFFF};
    list.push_back(d);
    d = '{32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 31'sh4000_0000, 31'sh4000_0000,
          31'h7FFF_FFFF};
    list.push_back(d);
    d = '{32'sh2D41_3CCD, 31'h2000_0000, 32'sh3FFF_FFFF, 31'sd421657428, 31'sd210828714,
          31'h3000_0000};
    list.push_back(d);
    d = '{32'sh0, 31'h0, 32'sh0, -31'sd421657428, -31'sd210828714, 31'h4000_0000};
    list.push_back(d);
    d = '{-32'sh1, 31'h1, -32'sh1, -31'sd1, 31'sd1, 31'h1};
    list.push_back(d);
    foreach (list[i]) send_decay(list[i]);
    drain();
  endtask

  task automatic test_config_extremes();
    logic [31:0] settings[4] = '{32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    decay_t d;
    foreach (settings[k]) begin
      for (int i = 0; i < NREG; i++) write_sdm(CFG_IDX_W'(i), settings[k]);
      d = '{32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 31'sd210828714, -31'sd421657428,
            31'h7FFF_FFFF};
      send_decay(d);
      d.s2t = 32'sh7FFF_FFFF;
      d.pp = 31'sd421657428;
      send_decay(d);
      repeat (8) send_decay(rand_decay());
      drain();
    end
  endtask

  task automatic test_unused_index();
    random_config();
    for (int i = NREG; i < (1 << CFG_IDX_W); i++) write_sdm(CFG_IDX_W'(i), $urandom());
    repeat (20) send_decay(rand_decay());
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    random_config();
    repeat (n) send_decay(rand_decay());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_config();
    hold_req = 1;
    repeat (100) send_decay(rand_decay());
    drain();
    repeat (30) send_decay(rand_decay());
    drain();
  endtask

  initial begin
    for (int i = 0; i < NREG; i++) sdm[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_config_extremes();
    test_unused_index();
    test_random_phase(0, 0, 100);
    test_random_phase(77, 0, 100);
    test_random_phase(0, 77, 100);
    test_random_phase(32, 32, 100);
    test_backpressure();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
design/vmdaw_pkg.sv
design/vmdaw_cordic_cell.sv
design/vmdaw_sqrt_cell.sv
design/vector_meson_decay_angular_weight.sv
test/vector_meson_decay_angular_weight_tb.sv
